/* sv/mptb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the microcode table of the MBR partition table builder.
package mptb_pkg;

  localparam int unsigned SLOTS     = 4;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned BLK_W     = 32;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CHS_W     = 24;

  localparam logic [7:0] ACTIVE_FLAG = 8'h80;
  localparam logic [7:0] BOOT_MARK_LO = 8'h55;
  localparam logic [7:0] BOOT_MARK_HI = 8'haa;

  // Fixed CHS geometry.
  localparam int unsigned CHS_SECTORS = 63;
  localparam int unsigned CHS_HEADS   = 255;
  localparam int unsigned CHS_CYL_MAX = 'h3ff;
  localparam logic [BLK_W-1:0] CHS_LBA_MAX = BLK_W'(CHS_SECTORS * CHS_HEADS * CHS_CYL_MAX);

  // Reciprocals rounded up; exact quotients for the ranges that reach them.
  localparam int unsigned CHS_SEC_SHIFT  = 30;
  localparam int unsigned CHS_HEAD_SHIFT = 27;
  localparam logic [24:0] CHS_SEC_RECIP =
    25'((64'd1 << CHS_SEC_SHIFT) / 64'(CHS_SECTORS) + 64'd1);
  localparam logic [19:0] CHS_HEAD_RECIP =
    20'((64'd1 << CHS_HEAD_SHIFT) / 64'(CHS_HEADS) + 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_BLOCKS,
    CFG_DISK_SIGNATURE
  } cfg_reg_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_AFTER_GROW,
    ERR_OVERLAP
  } err_code_e;

  typedef enum logic [4:0] {
    OP_ACCEPT,
    OP_CHK_LOAD,
    OP_CHK_GROW,
    OP_CHK_PAIR,
    OP_NEXT_I,
    OP_BLD_LOAD,
    OP_CHS_MUL1,
    OP_CHS_MUL2,
    OP_BLD_START,
    OP_BLD_END,
    OP_OUT_SIG,
    OP_OUT_A,
    OP_OUT_B,
    OP_OUT_C,
    OP_OUT_D,
    OP_OUT_END,
    OP_ERR_GROW,
    OP_ERR_OVL
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_LAST_IN,
    C_SKIP_I,
    C_GROWING,
    C_OVERLAP,
    C_J_MORE,
    C_I_MORE
  } cond_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK_LOAD,
    ST_CHK_GROW,
    ST_CHK_PAIR,
    ST_CHK_NEXT,
    ST_BLD_LOAD,
    ST_BLD_MUL1S,
    ST_BLD_MUL2S,
    ST_BLD_START,
    ST_BLD_MUL1E,
    ST_BLD_MUL2E,
    ST_BLD_END,
    ST_OUT_SIG,
    ST_OUT_A,
    ST_OUT_B,
    ST_OUT_C,
    ST_OUT_D,
    ST_OUT_END,
    ST_ERR_GROW,
    ST_ERR_OVL
  } step_e;

  typedef struct packed {
    op_e   op;
    cond_e cond_a;
    step_e tgt_a;
    cond_e cond_b;
    step_e tgt_b;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic last_in;
    logic skip_i;
    logic growing;
    logic overlap;
    logic j_more;
    logic i_more;
    logic stall;
  } stat_t;

  // Control store. Unless the datapath stalls, the first branch that holds wins; otherwise the step counter advances.
  function automatic uword_t ucode(step_e pc);
    uword_t w;
    case (pc)
      ST_IDLE:      w = '{OP_ACCEPT,    C_LAST_IN, ST_CHK_LOAD,  C_ALWAYS, ST_IDLE};
      ST_CHK_LOAD:  w = '{OP_CHK_LOAD,  C_SKIP_I,  ST_CHK_NEXT,  C_NEVER,  ST_IDLE};
      ST_CHK_GROW:  w = '{OP_CHK_GROW,  C_GROWING, ST_ERR_GROW,  C_NEVER,  ST_IDLE};
      ST_CHK_PAIR:  w = '{OP_CHK_PAIR,  C_OVERLAP, ST_ERR_OVL,   C_J_MORE, ST_CHK_PAIR};
      ST_CHK_NEXT:  w = '{OP_NEXT_I,    C_I_MORE,  ST_CHK_LOAD,  C_NEVER,  ST_IDLE};
      ST_BLD_LOAD:  w = '{OP_BLD_LOAD,  C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_BLD_MUL1S: w = '{OP_CHS_MUL1,  C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_BLD_MUL2S: w = '{OP_CHS_MUL2,  C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_BLD_START: w = '{OP_BLD_START, C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_BLD_MUL1E: w = '{OP_CHS_MUL1,  C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_BLD_MUL2E: w = '{OP_CHS_MUL2,  C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_BLD_END:   w = '{OP_BLD_END,   C_I_MORE,  ST_BLD_LOAD,  C_NEVER,  ST_IDLE};
      ST_OUT_SIG:   w = '{OP_OUT_SIG,   C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_OUT_A:     w = '{OP_OUT_A,     C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_OUT_B:     w = '{OP_OUT_B,     C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_OUT_C:     w = '{OP_OUT_C,     C_NEVER,   ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_OUT_D:     w = '{OP_OUT_D,     C_I_MORE,  ST_OUT_A,     C_NEVER,  ST_IDLE};
      ST_OUT_END:   w = '{OP_OUT_END,   C_ALWAYS,  ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_ERR_GROW:  w = '{OP_ERR_GROW,  C_ALWAYS,  ST_IDLE,      C_NEVER,  ST_IDLE};
      ST_ERR_OVL:   w = '{OP_ERR_OVL,   C_ALWAYS,  ST_IDLE,      C_NEVER,  ST_IDLE};
      default:      w = '{OP_ACCEPT,    C_NEVER,   ST_IDLE,      C_ALWAYS, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/mptb_desc_if.sv */
`timescale 1ns / 1ps
// Channel carrying one partition descriptor word.
interface mptb_desc_if;
  logic                              valid;
  logic                              ready;
  logic [mptb_pkg::TYPE_W-1:0]       part_type;
  logic                              bootable;
  logic                              grow_to_end;
  logic [mptb_pkg::BLK_W-1:0]        start_block;
  logic [mptb_pkg::BLK_W-1:0]        length_blocks;

  modport source (
    output valid, part_type, bootable, grow_to_end, start_block, length_blocks,
    input  ready
  );
  modport sink (
    input  valid, part_type, bootable, grow_to_end, start_block, length_blocks,
    output ready
  );
endinterface

/* sv/mptb_word_if.sv */
`timescale 1ns / 1ps
// Channel carrying one sector word or an error word.
interface mptb_word_if;
  logic                        valid;
  logic                        ready;
  logic [mptb_pkg::WORD_W-1:0] sector_word;
  logic [mptb_pkg::ERR_W-1:0]  error_code;
  logic                        last;

  modport source (
    output valid, sector_word, error_code, last,
    input  ready
  );
  modport sink (
    input  valid, sector_word, error_code, last,
    output ready
  );
endinterface

/* sv/mptb_seq.sv */
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and conditional branching.
module mptb_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mptb_pkg::stat_t stat_i,
  output mptb_pkg::ctrl_t ctrl_o
);

  mptb_pkg::step_e  pc_q, pc_d;
  mptb_pkg::uword_t uw;

  function automatic logic cond_hit(mptb_pkg::cond_e c, mptb_pkg::stat_t s);
    logic h;
    case (c)
      mptb_pkg::C_NEVER:   h = 1'b0;
      mptb_pkg::C_ALWAYS:  h = 1'b1;
      mptb_pkg::C_LAST_IN: h = s.last_in;
      mptb_pkg::C_SKIP_I:  h = s.skip_i;
      mptb_pkg::C_GROWING: h = s.growing;
      mptb_pkg::C_OVERLAP: h = s.overlap;
      mptb_pkg::C_J_MORE:  h = s.j_more;
      mptb_pkg::C_I_MORE:  h = s.i_more;
      default:             h = 1'b0;
    endcase
    return h;
  endfunction

  assign uw        = mptb_pkg::ucode(pc_q);
  assign ctrl_o.op = uw.op;

  always_comb begin
    if (stat_i.stall) begin
      pc_d = pc_q;
    end else if (cond_hit(uw.cond_a, stat_i)) begin
      pc_d = uw.tgt_a;
    end else if (cond_hit(uw.cond_b, stat_i)) begin
      pc_d = uw.tgt_b;
    end else begin
      pc_d = mptb_pkg::step_e'(5'(pc_q + 5'd1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mptb_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* sv/mptb_chs.sv */
`timescale 1ns / 1ps
// Block address to CHS conversion in two multiply steps with reciprocal constants.
module mptb_chs (
  input  logic                        clk_i,
  input  logic [mptb_pkg::BLK_W-1:0]  lba_i,
  input  logic                        mul1_i,
  input  logic                        mul2_i,
  output logic [mptb_pkg::CHS_W-1:0]  chs_o
);

  logic [48:0] prod1;
  logic [37:0] prod2;
  logic [17:0] q1_q;
  logic [9:0]  q2_q;
  logic        rep_q;
  logic [17:0] q2x255;
  logic [17:0] head_full;
  logic [23:0] q1x63;
  logic [23:0] rem;
  logic [5:0]  sec;

  assign prod1 = 49'(lba_i[23:0]) * 49'(mptb_pkg::CHS_SEC_RECIP);
  assign prod2 = 38'(q1_q) * 38'(mptb_pkg::CHS_HEAD_RECIP);

  // Quotient by 63 is the track count; by 255 tracks it gives the cylinder.
  always_ff @(posedge clk_i) begin
    if (mul1_i) begin
      q1_q  <= prod1[47:30];
      rep_q <= (lba_i <= mptb_pkg::CHS_LBA_MAX);
    end
    if (mul2_i) begin
      q2_q <= prod2[36:27];
    end
  end

  always_comb begin
    q2x255    = ({8'b0, q2_q} << 8) - {8'b0, q2_q};
    head_full = q1_q - q2x255;
    q1x63     = ({6'b0, q1_q} << 6) - {6'b0, q1_q};
    rem       = lba_i[23:0] - q1x63;
    sec       = rem[5:0] + 6'd1;
    if (rep_q) begin
      chs_o = {q2_q[7:0], q2_q[9:8], sec, head_full[7:0]};
    end else begin
      chs_o = '0;
    end
  end

endmodule

/* sv/mptb_dp.sv */
`timescale 1ns / 1ps
// Datapath: descriptor store, table checks, entry build and the output word register.
module mptb_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mptb_pkg::ctrl_t            ctrl_i,
  output mptb_pkg::stat_t            stat_o,
  input  logic [mptb_pkg::BLK_W-1:0] total_blocks_i,
  input  logic [mptb_pkg::BLK_W-1:0] disk_signature_i,
  mptb_desc_if.sink                  desc_i,
  mptb_word_if.source                word_o
);

  typedef struct packed {
    logic [mptb_pkg::TYPE_W-1:0] ptype;
    logic                        boot;
    logic                        grow;
    logic [mptb_pkg::BLK_W-1:0]  lo;
    logic [mptb_pkg::BLK_W-1:0]  len;
    logic [mptb_pkg::BLK_W-1:0]  hi;
  } slot_t;

  mptb_pkg::op_e op;

  slot_t       slot_q [mptb_pkg::SLOTS];
  logic [63:0] hdr_q  [mptb_pkg::SLOTS];
  slot_t       in_slot;
  slot_t       rd;

  logic [mptb_pkg::IDX_W-1:0] i_q, i_d, j_q, j_d, fill_q, fill_d, rd_idx;
  logic growing_q, growing_d;
  logic out_valid_q, out_valid_d;

  logic [mptb_pkg::BLK_W-1:0]  cur_lo_q, cur_hi_q;
  logic                        cur_grow_q;
  logic [mptb_pkg::BLK_W-1:0]  lba_q, lba_end_q;
  logic [mptb_pkg::CHS_W-1:0]  chs_s_q, chs;
  logic [15:0]                 carry_q;
  logic [mptb_pkg::WORD_W-1:0] out_word_q, word_d;
  logic [mptb_pkg::ERR_W-1:0]  out_err_q;
  logic                        out_last_q, last_d;
  mptb_pkg::err_code_e         err_d;

  logic                        accept, emit, stall, go, expand;
  logic [mptb_pkg::BLK_W-1:0]  len_new, lba_end_new;
  logic [127:0]                rec;
  logic [7:0]                  boot_byte;

  assign op           = ctrl_i.op;
  assign desc_i.ready = (op == mptb_pkg::OP_ACCEPT);
  assign accept       = desc_i.ready && desc_i.valid;

  assign in_slot.ptype = desc_i.part_type;
  assign in_slot.boot  = desc_i.bootable;
  assign in_slot.grow  = desc_i.grow_to_end;
  assign in_slot.lo    = desc_i.start_block;
  assign in_slot.len   = desc_i.length_blocks;
  assign in_slot.hi    = desc_i.start_block + desc_i.length_blocks;

  // Pair checks read the other entry; every other step reads the current one.
  assign rd_idx = (op == mptb_pkg::OP_CHK_PAIR) ? j_q : i_q;
  assign rd     = slot_q[rd_idx];

  assign emit  = op inside {mptb_pkg::OP_OUT_SIG, mptb_pkg::OP_OUT_A, mptb_pkg::OP_OUT_B,
                            mptb_pkg::OP_OUT_C, mptb_pkg::OP_OUT_D, mptb_pkg::OP_OUT_END,
                            mptb_pkg::OP_ERR_GROW, mptb_pkg::OP_ERR_OVL};
  assign stall = emit && out_valid_q && !word_o.ready;
  assign go    = !stall;

  // Growing to the device end: when total_blocks lies beyond the entry's end, the last block becomes total_blocks - 1.
  assign expand      = rd.grow && (total_blocks_i > rd.hi);
  assign len_new     = expand ? (total_blocks_i - rd.lo) : rd.len;
  assign lba_end_new = expand ? (total_blocks_i - 32'd1) : (rd.hi - 32'd1);
  assign boot_byte   = rd.boot ? mptb_pkg::ACTIVE_FLAG : 8'h00;

  // Entry bytes 0..15, lowest byte first.
  assign rec = {rd.len, rd.lo, hdr_q[i_q]};

  assign stat_o.last_in = desc_i.valid && (fill_q == mptb_pkg::IDX_W'(mptb_pkg::SLOTS - 1));
  assign stat_o.skip_i  = (rd.ptype == '0) || ((rd.len == '0) && !rd.grow);
  assign stat_o.growing = growing_q;
  assign stat_o.overlap = (j_q != i_q) && (rd.ptype != '0) && (rd.len != '0) &&
                          (((cur_lo_q >= rd.lo) && (cur_lo_q < rd.hi)) ||
                           ((cur_hi_q > rd.lo) && (cur_hi_q <= rd.hi)));
  assign stat_o.j_more  = (j_q != mptb_pkg::IDX_W'(mptb_pkg::SLOTS - 1));
  assign stat_o.i_more  = (i_q != mptb_pkg::IDX_W'(mptb_pkg::SLOTS - 1));
  assign stat_o.stall   = stall;

  mptb_chs u_chs (
    .clk_i  (clk_i),
    .lba_i  (lba_q),
    .mul1_i (op == mptb_pkg::OP_CHS_MUL1),
    .mul2_i (op == mptb_pkg::OP_CHS_MUL2),
    .chs_o  (chs)
  );

  always_comb begin
    word_d = '0;
    err_d  = mptb_pkg::ERR_NONE;
    last_d = 1'b0;
    case (op)
      mptb_pkg::OP_OUT_SIG:  word_d = disk_signature_i;
      mptb_pkg::OP_OUT_A:    word_d = {rec[15:0], carry_q};
      mptb_pkg::OP_OUT_B:    word_d = rec[47:16];
      mptb_pkg::OP_OUT_C:    word_d = rec[79:48];
      mptb_pkg::OP_OUT_D:    word_d = rec[111:80];
      mptb_pkg::OP_OUT_END: begin
        word_d = {mptb_pkg::BOOT_MARK_HI, mptb_pkg::BOOT_MARK_LO, carry_q};
        last_d = 1'b1;
      end
      mptb_pkg::OP_ERR_GROW: begin
        err_d  = mptb_pkg::ERR_AFTER_GROW;
        last_d = 1'b1;
      end
      mptb_pkg::OP_ERR_OVL: begin
        err_d  = mptb_pkg::ERR_OVERLAP;
        last_d = 1'b1;
      end
      default: begin
        word_d = '0;
      end
    endcase
  end

  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    fill_d      = fill_q;
    growing_d   = growing_q;
    out_valid_d = out_valid_q;
    if (op == mptb_pkg::OP_ACCEPT) begin
      i_d       = '0;
      growing_d = 1'b0;
    end
    if ((op == mptb_pkg::OP_NEXT_I || op == mptb_pkg::OP_BLD_END ||
         op == mptb_pkg::OP_OUT_D) && go) begin
      i_d = mptb_pkg::IDX_W'(i_q + 1'b1);
    end
    if (op == mptb_pkg::OP_CHK_LOAD) begin
      j_d = '0;
    end else if (op == mptb_pkg::OP_CHK_PAIR) begin
      j_d = mptb_pkg::IDX_W'(j_q + 1'b1);
    end
    if (op == mptb_pkg::OP_CHK_GROW) begin
      growing_d = growing_q | cur_grow_q;
    end
    if (accept) begin
      fill_d = mptb_pkg::IDX_W'(fill_q + 1'b1);
    end
    if (emit && go) begin
      out_valid_d = 1'b1;
    end else if (word_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      fill_q      <= '0;
      growing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      fill_q      <= fill_d;
      growing_q   <= growing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[fill_q] <= in_slot;
    end
    if (op == mptb_pkg::OP_CHK_LOAD) begin
      cur_lo_q   <= rd.lo;
      cur_hi_q   <= rd.hi;
      cur_grow_q <= rd.grow;
    end
    if (op == mptb_pkg::OP_BLD_LOAD) begin
      slot_q[i_q].len <= len_new;
      lba_q           <= rd.lo;
      lba_end_q       <= lba_end_new;
    end
    if (op == mptb_pkg::OP_BLD_START) begin
      chs_s_q <= chs;
      lba_q   <= lba_end_q;
    end
    if (op == mptb_pkg::OP_BLD_END) begin
      // An unused entry keeps its first eight bytes clear.
      hdr_q[i_q] <= (rd.ptype != '0) ? {chs, rd.ptype, chs_s_q, boot_byte} : '0;
    end
    if (go && op == mptb_pkg::OP_OUT_SIG) begin
      carry_q <= '0;
    end else if (go && op == mptb_pkg::OP_OUT_D) begin
      carry_q <= rec[127:112];
    end
    if (emit && go) begin
      out_word_q <= word_d;
      out_err_q  <= err_d;
      out_last_q <= last_d;
    end
  end

  assign word_o.valid       = out_valid_q;
  assign word_o.sector_word = out_word_q;
  assign word_o.error_code  = out_err_q;
  assign word_o.last        = out_last_q;

endmodule

/* sv/mbr_partition_table_builder_core.sv */
`timescale 1ns / 1ps
// Takes four partition descriptors in slot order, one word per cycle while the sequencer
// waits in its idle step. After the fourth it checks the table: a slot that is skipped
// has only a load and a step on to the next, and one that is checked has one load, one
// grow test, one overlap test against each slot and one step on to the next. It then
// builds the four entries, with two multiply steps per CHS value in the shared multiply
// unit. It then sends bytes 440 to 511 of the boot record as 18 words, one per cycle
// while the sink takes them, or a single error word with last set. A table that fails
// ends sooner, with no entries built. The next descriptor is taken as soon as the last
// word sits in the output register. Register writes are taken at any time.
module mbr_partition_table_builder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mptb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mptb_pkg::CFG_W-1:0]     cfg_data_i,
  mptb_desc_if.sink                      desc_i,
  mptb_word_if.source                    word_o
);

  logic [mptb_pkg::BLK_W-1:0] total_blocks_q, total_blocks_d;
  logic [mptb_pkg::BLK_W-1:0] disk_signature_q, disk_signature_d;
  mptb_pkg::ctrl_t            ctrl;
  mptb_pkg::stat_t            stat;

  always_comb begin
    total_blocks_d   = total_blocks_q;
    disk_signature_d = disk_signature_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mptb_pkg::CFG_TOTAL_BLOCKS:   total_blocks_d   = cfg_data_i;
        mptb_pkg::CFG_DISK_SIGNATURE: disk_signature_d = cfg_data_i;
        default: begin
          total_blocks_d = total_blocks_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q   <= '0;
      disk_signature_q <= '0;
    end else begin
      total_blocks_q   <= total_blocks_d;
      disk_signature_q <= disk_signature_d;
    end
  end

  mptb_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mptb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .total_blocks_i   (total_blocks_q),
    .disk_signature_i (disk_signature_q),
    .desc_i           (desc_i),
    .word_o           (word_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the MBR partition table builder: directed tables, then random ones.
module testbench;

  localparam int unsigned SLOT_N           = 4;
  localparam int unsigned SECTOR_BYTES     = 72;
  localparam int unsigned SECTOR_WORDS     = 18;
  localparam int unsigned ENTRY_BASE       = 6;
  localparam int unsigned ENTRY_BYTES      = 16;
  localparam int unsigned GEO_SECTORS      = 63;
  localparam int unsigned GEO_HEADS        = 255;
  localparam int unsigned GEO_CYL_MAX      = 'h3ff;
  localparam logic [31:0] CHS_LBA_LIMIT    = 32'(GEO_SECTORS * GEO_HEADS * GEO_CYL_MAX);
  localparam int unsigned DIRECTED_ROWS    = 24;
  localparam int unsigned RANDOM_TABLES    = 49;
  localparam int unsigned TABLES_PER_PHASE = 6;
  localparam int unsigned SETTLE_CYCLES    = 100;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned QUIET_LIMIT      = 4000;

  typedef struct packed {
    logic [7:0]  part_type;
    logic        bootable;
    logic        grow_to_end;
    logic [31:0] start_block;
    logic [31:0] length_blocks;
  } desc_t;

  typedef struct packed {
    desc_t               d;
    logic                typed;
    mptb_pkg::err_code_e typed_err;
  } plan_row_t;

  typedef struct packed {
    logic [31:0]         sector_word;
    mptb_pkg::err_code_e error_code;
    logic                last;
  } sector_out_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [mptb_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [mptb_pkg::CFG_W-1:0]     cfg_data_i;

  mptb_desc_if desc_ch ();
  mptb_word_if word_ch ();

  mbr_partition_table_builder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .desc_i     (desc_ch),
    .word_o     (word_ch)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the block: stored slots, fill position and the two registers.
  desc_t       held [SLOT_N];
  int unsigned held_count = 0;
  logic [31:0] total_blocks_q = '0;
  logic [31:0] signature_q = '0;

  sector_out_t sector_expect_q [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  desc_t       tbl [SLOT_N];

  // Directed tables. Only the error rows carry a typed-in expectation.
  plan_row_t plan [DIRECTED_ROWS] = '{
    // All slots unused at reset settings; start and length are still written.
    '{'{8'h00, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b1, 1'b0, 32'h1234_5678, 32'h0000_0000}, 1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b0, 1'b1, 32'h0000_0000, 32'hffff_ffff}, 1'b0, mptb_pkg::ERR_NONE},
    // Valid table, CHS at its limit and beyond it.
    '{'{8'h0c, 1'b1, 1'b0, 32'd2048,      32'd100000},    1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h83, 1'b0, 1'b0, 32'h00ff_0000, 32'd256},       1'b0, mptb_pkg::ERR_NONE},
    '{'{8'hff, 1'b1, 1'b0, 32'hffff_0000, 32'd1000},      1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h07, 1'b0, 1'b0, 32'd16434495,  32'd1},         1'b0, mptb_pkg::ERR_NONE},
    // Expansion to the device end, with an empty entry before it.
    '{'{8'h01, 1'b0, 1'b0, 32'd1,         32'd62},        1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h0b, 1'b1, 1'b0, 32'd500,       32'd0},         1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h83, 1'b0, 1'b1, 32'd1000,      32'd10},        1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b0, 1'b0, 32'd0,         32'd0},         1'b0, mptb_pkg::ERR_NONE},
    // A used entry after an expanding one.
    '{'{8'h83, 1'b0, 1'b1, 32'd0,         32'd100},       1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h07, 1'b0, 1'b0, 32'd200,       32'd10},        1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b0, 1'b0, 32'd0,         32'd0},         1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h05, 1'b0, 1'b0, 32'd400,       32'd1},         1'b1, mptb_pkg::ERR_AFTER_GROW},
    // A range nested inside another.
    '{'{8'h01, 1'b0, 1'b0, 32'd100,       32'd50},        1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h02, 1'b0, 1'b0, 32'd120,       32'd10},        1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b0, 1'b0, 32'd0,         32'd0},         1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b0, 1'b0, 32'd0,         32'd0},         1'b1, mptb_pkg::ERR_OVERLAP},
    // A range wrapping past the top of the block space, and an empty expanding entry.
    '{'{8'h01, 1'b0, 1'b0, 32'hffff_fff0, 32'd32},        1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h02, 1'b1, 1'b0, 32'd5,         32'd5},         1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h0c, 1'b0, 1'b1, 32'd4096,      32'd0},         1'b0, mptb_pkg::ERR_NONE},
    '{'{8'h00, 1'b0, 1'b0, 32'd0,         32'd0},         1'b0, mptb_pkg::ERR_NONE}
  };

  function automatic logic [23:0] chs_of(input logic [31:0] lba);
    logic [31:0] cyl, head, sec;
    cyl  = lba / (GEO_SECTORS * GEO_HEADS);
    head = (lba / GEO_SECTORS) % GEO_HEADS;
    sec  = lba % GEO_SECTORS + 32'd1;
    if (lba > CHS_LBA_LIMIT) return 24'd0;
    return {cyl[7:0], 8'(((cyl & 32'h300) >> 2) | sec), head[7:0]};
  endfunction

  function automatic mptb_pkg::err_code_e audit_table();
    bit          growing;
    logic [31:0] lo, hi, lo2, hi2;
    growing = 1'b0;
    for (int i = 0; i < SLOT_N; i++) begin
      lo = held[i].start_block;
      hi = lo + held[i].length_blocks;
      if (held[i].part_type == 8'd0) continue;
      if (lo == hi && !held[i].grow_to_end) continue;
      if (growing) return mptb_pkg::ERR_AFTER_GROW;
      if (held[i].grow_to_end) growing = 1'b1;
      for (int j = 0; j < SLOT_N; j++) begin
        if (j == i) continue;
        lo2 = held[j].start_block;
        hi2 = lo2 + held[j].length_blocks;
        if (held[j].part_type == 8'd0 || lo2 == hi2) continue;
        if ((lo >= lo2 && lo < hi2) || (hi > lo2 && hi <= hi2)) return mptb_pkg::ERR_OVERLAP;
      end
    end
    return mptb_pkg::ERR_NONE;
  endfunction

  task automatic queue_sector_words();
    logic [7:0]  img [SECTOR_BYTES];
    logic [31:0] start, len, stop;
    logic [23:0] chs;
    int unsigned base;
    sector_out_t w;
    foreach (img[b]) img[b] = 8'd0;
    {img[3], img[2], img[1], img[0]} = signature_q;
    for (int i = 0; i < SLOT_N; i++) begin
      base  = ENTRY_BASE + ENTRY_BYTES * i;
      start = held[i].start_block;
      len   = held[i].length_blocks;
      stop  = start + len;
      if (held[i].grow_to_end && total_blocks_q > stop) len = total_blocks_q - start;
      if (held[i].part_type != 8'd0) begin
        img[base] = held[i].bootable ? 8'h80 : 8'h00;
        chs = chs_of(start);
        {img[base+3], img[base+2], img[base+1]} = chs;
        img[base+4] = held[i].part_type;
        stop = start + len - 32'd1;
        chs = chs_of(stop);
        {img[base+7], img[base+6], img[base+5]} = chs;
      end
      {img[base+11], img[base+10], img[base+9], img[base+8]}  = start;
      {img[base+15], img[base+14], img[base+13], img[base+12]} = len;
    end
    img[SECTOR_BYTES-2] = 8'h55;
    img[SECTOR_BYTES-1] = 8'haa;
    for (int k = 0; k < SECTOR_WORDS; k++) begin
      w.sector_word = {img[4*k+3], img[4*k+2], img[4*k+1], img[4*k]};
      w.error_code  = mptb_pkg::ERR_NONE;
      w.last        = (k == SECTOR_WORDS - 1);
      sector_expect_q.push_back(w);
    end
  endtask

  // Store an accepted descriptor; the fourth one completes the table.
  task automatic absorb_desc(input desc_t d, input bit typed,
                             input mptb_pkg::err_code_e typed_err);
    mptb_pkg::err_code_e fault;
    held[held_count] = d;
    if (held_count < SLOT_N - 1) begin
      held_count++;
      return;
    end
    held_count = 0;
    fault = audit_table();
    if (typed) begin
      sector_expect_q.push_back(sector_out_t'{32'd0, typed_err, 1'b1});
    end else if (fault != mptb_pkg::ERR_NONE) begin
      sector_expect_q.push_back(sector_out_t'{32'd0, fault, 1'b1});
    end else begin
      queue_sector_words();
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_desc(input desc_t d, input bit typed,
                           input mptb_pkg::err_code_e typed_err);
    if (burst_left == 0) begin
      desc_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    end
    desc_ch.valid         = 1'b1;
    desc_ch.part_type     = d.part_type;
    desc_ch.bootable      = d.bootable;
    desc_ch.grow_to_end   = d.grow_to_end;
    desc_ch.start_block   = d.start_block;
    desc_ch.length_blocks = d.length_blocks;
    @(posedge clk_i);
    while (!desc_ch.ready) @(posedge clk_i);
    absorb_desc(d, typed, typed_err);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Hold the input back until every expected word has come and the block is quiet.
  task automatic settle_block();
    desc_ch.valid = 1'b0;
    burst_left = 0;
    while (sector_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input mptb_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      mptb_pkg::CFG_TOTAL_BLOCKS:   total_blocks_q = val;
      mptb_pkg::CFG_DISK_SIGNATURE: signature_q    = val;
      default: ;
    endcase
  endtask

  // Non-overlapping ranges in ascending order, at most one expanding entry and nothing
  // used after it.
  task automatic compose_clean_table();
    longint unsigned cursor, lo, span;
    int              grow_at, kind;
    bit              spread;
    spread  = ($urandom_range(0, 3) == 0);
    cursor  = spread ? $urandom : $urandom_range(0, 20_000_000);
    grow_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, SLOT_N - 1) : SLOT_N;
    for (int s = 0; s < SLOT_N; s++) begin
      if (s > grow_at) kind = $urandom_range(0, 1);
      else if (s == grow_at) kind = 2;
      else kind = $urandom_range(0, 5);
      tbl[s].part_type     = 8'($urandom_range(1, 255));
      tbl[s].bootable      = 1'($urandom_range(0, 1));
      tbl[s].grow_to_end   = 1'b0;
      tbl[s].start_block   = $urandom;
      tbl[s].length_blocks = 32'd0;
      if (kind == 0) begin
        tbl[s].part_type     = 8'd0;
        tbl[s].grow_to_end   = 1'($urandom_range(0, 1));
        tbl[s].length_blocks = $urandom;
      end else if (kind >= 2) begin
        lo   = cursor + $urandom_range(1, 5000);
        span = spread ? $urandom_range(1, 32'h0fff_ffff) : $urandom_range(1, 4_000_000);
        if (s == grow_at && $urandom_range(0, 3) == 0) span = 0;
        if (lo + span >= 64'h1_0000_0000) begin
          tbl[s].part_type = 8'd0;
        end else begin
          cursor               = lo + span;
          tbl[s].start_block   = 32'(lo);
          tbl[s].length_blocks = 32'(span);
          tbl[s].grow_to_end   = (s == grow_at);
        end
      end
    end
  endtask

  initial begin : main_seq
    int unsigned a, b, pick;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = mptb_pkg::CFG_TOTAL_BLOCKS;
    cfg_data_i            = '0;
    desc_ch.valid         = 1'b0;
    desc_ch.part_type     = '0;
    desc_ch.bootable      = 1'b0;
    desc_ch.grow_to_end   = 1'b0;
    desc_ch.start_block   = '0;
    desc_ch.length_blocks = '0;
    rst_ni                = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // The first table runs on the register values left by reset.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (r == SLOT_N) begin
        settle_block();
        write_reg(mptb_pkg::CFG_TOTAL_BLOCKS, 32'h0100_0000);
        write_reg(mptb_pkg::CFG_DISK_SIGNATURE, 32'hffff_ffff);
      end
      send_desc(plan[r].d, plan[r].typed, plan[r].typed_err);
    end

    for (int t = 0; t < RANDOM_TABLES; t++) begin
      if (t % TABLES_PER_PHASE == 0) begin
        settle_block();
        case ((t / TABLES_PER_PHASE) % 6)
          0: write_reg(mptb_pkg::CFG_TOTAL_BLOCKS, 32'd0);
          1: write_reg(mptb_pkg::CFG_TOTAL_BLOCKS, 32'hffff_ffff);
          2: write_reg(mptb_pkg::CFG_TOTAL_BLOCKS, $urandom_range(0, 40_000_000));
          3: write_reg(mptb_pkg::CFG_TOTAL_BLOCKS, $urandom);
          4: write_reg(mptb_pkg::CFG_TOTAL_BLOCKS, CHS_LBA_LIMIT + 32'd1);
          default: write_reg(mptb_pkg::CFG_TOTAL_BLOCKS,
                             $urandom_range(20_000_000, 30_000_000));
        endcase
        case ((t / TABLES_PER_PHASE) % 3)
          0: write_reg(mptb_pkg::CFG_DISK_SIGNATURE, 32'hffff_ffff);
          1: write_reg(mptb_pkg::CFG_DISK_SIGNATURE, 32'd0);
          default: write_reg(mptb_pkg::CFG_DISK_SIGNATURE, $urandom);
        endcase
        // The output side stops for a while so that the block backs up.
        if (t == 0) hold_req = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        for (int s = 0; s < SLOT_N; s++) begin
          tbl[s].part_type     = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
          tbl[s].bootable      = 1'($urandom_range(0, 1));
          tbl[s].grow_to_end   = ($urandom_range(0, 3) == 0);
          tbl[s].start_block   = $urandom;
          tbl[s].length_blocks = ($urandom_range(0, 1) == 0) ? $urandom
                                                             : $urandom_range(0, 100_000);
        end
      end else begin
        compose_clean_table();
        if (pick == 1) begin
          a = $urandom_range(0, SLOT_N - 1);
          b = (a + $urandom_range(1, SLOT_N - 1)) % SLOT_N;
          if ($urandom_range(0, 1) == 0) begin
            tbl[b].start_block = tbl[a].start_block + $urandom_range(0, 3);
          end else begin
            tbl[a].grow_to_end = 1'b1;
            if (tbl[a].part_type == 8'd0) tbl[a].part_type = 8'h83;
          end
        end
      end
      for (int s = 0; s < SLOT_N; s++) send_desc(tbl[s], 1'b0, mptb_pkg::ERR_NONE);
    end

    settle_block();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Output side: stretches of different stall patterns, and one long hold-off on request.
  initial begin : sink_side
    int unsigned mode, stretch;
    word_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        word_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(5, 60);
      for (int k = 0; k < stretch; k++) begin
        @(negedge clk_i);
        case (mode)
          0: word_ch.ready = 1'b1;
          1: word_ch.ready = 1'($urandom_range(0, 1));
          2: word_ch.ready = (k % 3 != 0);
          default: word_ch.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : word_check
    sector_out_t want;
    if (word_ch.valid && word_ch.ready) begin
      if (sector_expect_q.size() == 0) begin
        fail_count++;
        $display("%0t: nothing expected, got word %h err %0d last %0d",
                 $time, word_ch.sector_word, word_ch.error_code, word_ch.last);
      end else begin
        want = sector_expect_q.pop_front();
        if (word_ch.sector_word !== want.sector_word) begin
          fail_count++;
          $display("%0t: sector_word expected %h, got %h",
                   $time, want.sector_word, word_ch.sector_word);
        end
        if (word_ch.error_code !== want.error_code) begin
          fail_count++;
          $display("%0t: error_code expected %0d, got %0d",
                   $time, want.error_code, word_ch.error_code);
        end
        if (word_ch.last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %0d, got %0d", $time, want.last, word_ch.last);
        end
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((desc_ch.valid && desc_ch.ready) || (word_ch.valid && word_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

/* files.f */
sv/mptb_pkg.sv
sv/mptb_desc_if.sv
sv/mptb_word_if.sv
sv/mptb_seq.sv
sv/mptb_chs.sv
sv/mptb_dp.sv
sv/mbr_partition_table_builder_core.sv
tb/testbench.sv
